@@ rtl/core/smp_pkg.sv @@
`default_nettype none
package smp_pkg;

  typedef enum logic [1:0] {
    PH_WHO   = 2'd0,
    PH_OPST  = 2'd1,
    PH_PERMS = 2'd2,
    PH_COPY  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_SET = 2'd2
  } op_t;

  typedef struct packed {
    phase_t      phase;
    logic [11:0] running_mode;
    logic [11:0] class_mask;
    op_t         pending_op;
    logic [11:0] pending_operand;
    logic [11:0] octal_value;
    logic        octal_overflow;
    logic        all_octal;
    logic        symbolic_error;
    logic        target_is_dir;
  } smp_state_t;

  localparam logic [11:0] MASK_USER   = 12'o4700;
  localparam logic [11:0] MASK_GROUP  = 12'o2070;
  localparam logic [11:0] MASK_OTHER  = 12'o0007;
  localparam logic [11:0] MASK_ALL    = 12'o6777;
  localparam logic [11:0] MASK_NOWHO  = 12'o1000;
  localparam logic [11:0] BITS_READ   = 12'o0444;
  localparam logic [11:0] BITS_WRITE  = 12'o0222;
  localparam logic [11:0] BITS_EXEC   = 12'o0111;
  localparam logic [11:0] BITS_SETID  = 12'o6000;
  localparam logic [11:0] UMASK_RESET = 12'o0022;

  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XCAP  = 8'h58;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  localparam smp_state_t STATE_RESET = '{
    phase:           PH_WHO,
    running_mode:    12'o0000,
    class_mask:      MASK_NOWHO,
    pending_op:      OP_ADD,
    pending_operand: 12'o0000,
    octal_value:     12'o0000,
    octal_overflow:  1'b0,
    all_octal:       1'b1,
    symbolic_error:  1'b0,
    target_is_dir:   1'b0
  };

  function automatic logic [11:0] apply_op(input logic [11:0] mode, input op_t op,
                                           input logic [11:0] operand,
                                           input logic [11:0] mask);
    logic [11:0] sel;
    logic [11:0] res;
    sel = operand & mask;
    case (op)
      OP_ADD:  res = mode | sel;
      OP_SUB:  res = mode & ~sel;
      OP_SET:  res = (mode & ~mask) | sel;
      default: res = mode;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/smp_step.sv @@
`default_nettype none
module smp_step import smp_pkg::*; (
  input  smp_state_t  state_cur,
  input  logic [7:0]  ch,
  input  logic        first,
  input  logic [11:0] start_mode,
  input  logic        is_directory,
  input  logic [11:0] umask_bits,
  output smp_state_t  state_next,
  output logic [11:0] final_mode,
  output logic        invalid
);

  smp_state_t  s0;
  smp_state_t  s;
  logic        is_op;
  op_t         op_val;
  logic        is_perm;
  logic [11:0] perm_bits;
  logic [2:0]  triple;
  logic [11:0] copy_opd;
  logic        do_end;

  always_comb begin
    // first character restarts the parse from the loaded mode
    s0 = state_cur;
    if (first) begin
      s0 = STATE_RESET;
      s0.running_mode = start_mode;
      s0.target_is_dir = is_directory;
    end

    is_op = 1'b1;
    case (ch)
      CH_PLUS:  op_val = OP_ADD;
      CH_MINUS: op_val = OP_SUB;
      CH_EQ:    op_val = OP_SET;
      default: begin
        op_val = OP_ADD;
        is_op = 1'b0;
      end
    endcase

    is_perm = 1'b1;
    case (ch)
      CH_R:    perm_bits = BITS_READ;
      CH_W:    perm_bits = BITS_WRITE;
      CH_X:    perm_bits = BITS_EXEC;
      CH_XCAP: perm_bits = (s0.target_is_dir || |(s0.running_mode & BITS_EXEC)) ?
                           BITS_EXEC : 12'o0000;
      CH_S:    perm_bits = BITS_SETID;
      CH_T:    perm_bits = 12'o0000;
      default: begin
        perm_bits = 12'o0000;
        is_perm = 1'b0;
      end
    endcase

    case (ch)
      CH_U:    triple = s0.running_mode[8:6];
      CH_G:    triple = s0.running_mode[5:3];
      default: triple = s0.running_mode[2:0];
    endcase
    copy_opd = {3'b000, triple, triple, triple};
    if ((ch == CH_U && s0.running_mode[11]) || (ch == CH_G && s0.running_mode[10])) begin
      copy_opd = copy_opd | BITS_SETID;
    end

    s = s0;
    if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
      if (s0.octal_value[11:9] != 3'b000) begin
        s.octal_overflow = 1'b1;
      end
      s.octal_value = {s0.octal_value[8:0], ch[2:0]};
    end else begin
      s.all_octal = 1'b0;
    end

    do_end = 1'b0;
    if (!s0.symbolic_error) begin
      case (s0.phase)
        PH_WHO: begin
          if (ch == CH_U) begin
            s.class_mask = s0.class_mask | MASK_USER;
          end else if (ch == CH_G) begin
            s.class_mask = s0.class_mask | MASK_GROUP;
          end else if (ch == CH_O) begin
            s.class_mask = s0.class_mask | MASK_OTHER;
          end else if (ch == CH_A) begin
            s.class_mask = s0.class_mask | MASK_ALL;
          end else if (!is_op) begin
            s.symbolic_error = 1'b1;
          end else begin
            // no class named: everything the umask lets through
            if (s0.class_mask[8:0] == 9'd0) begin
              s.class_mask = s0.class_mask | (MASK_ALL & ~umask_bits);
            end
            s.pending_op = op_val;
            s.pending_operand = 12'o0000;
            s.phase = PH_OPST;
          end
        end
        PH_OPST, PH_PERMS: begin
          if (s0.phase == PH_OPST && (ch == CH_U || ch == CH_G || ch == CH_O)) begin
            s.pending_operand = copy_opd;
            s.class_mask = s0.class_mask & ~MASK_NOWHO;
            s.phase = PH_COPY;
          end else if (is_perm) begin
            s.pending_operand = s0.pending_operand | perm_bits;
            s.phase = PH_PERMS;
          end else begin
            do_end = 1'b1;
          end
        end
        PH_COPY: do_end = 1'b1;
        default: s.symbolic_error = 1'b1;
      endcase
    end

    if (do_end) begin
      s.running_mode = apply_op(s0.running_mode, s0.pending_op, s0.pending_operand,
                                s0.class_mask);
      if (is_op) begin
        s.pending_op = op_val;
        s.pending_operand = 12'o0000;
        s.phase = PH_OPST;
      end else if (ch == CH_COMMA) begin
        s.phase = PH_WHO;
        s.class_mask = MASK_NOWHO;
      end else begin
        s.symbolic_error = 1'b1;
      end
    end

    state_next = s;

    if (s.all_octal) begin
      final_mode = s.octal_overflow ? 12'o0000 : s.octal_value;
      invalid = s.octal_overflow;
    end else if (s.symbolic_error || s.phase == PH_WHO) begin
      final_mode = 12'o0000;
      invalid = 1'b1;
    end else begin
      // open operation is shown, not committed
      final_mode = apply_op(s.running_mode, s.pending_op, s.pending_operand, s.class_mask);
      invalid = 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/symbolic_mode_parser.sv @@
`default_nettype none
// Symbolic / octal file-mode specification parser.
// s_* channel: one character per transaction. s_tdata holds ch, start_mode and
//   is_directory; s_tuser marks the first character (parser restarts and takes
//   start_mode / is_directory); s_tlast marks the final character.
// m_* channel: one transaction per final character with the resulting mode in
//   m_tdata and the invalid flag in m_tuser (the mode is zero when invalid).
// cfg_*: writes umask_bits; always ready. Write only while the block is idle.
// Throughput: one character per cycle while no final character waits on a stalled
//   receiver. Each character is held in the input register until the parser state
//   register takes its next state; for a final character the result register and
//   m_tvalid load at that same edge.
// When the receiver stalls, the result holds in the output register and
//   characters without tlast keep flowing; a final character waits in the
//   input register until the output register frees, and s_tready drops then.
// Reset restores the parser state (zero running mode), clears the valid flags of both
//   registers and sets umask_bits to 022 octal. No result is pending after reset.
module symbolic_mode_parser import smp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // ch[7:0], start_mode[19:8], is_directory[20], zero pad
  input  wire logic [0:0]  s_tuser,  // first[0]
  input  wire logic        s_tlast,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,  // final_mode[11:0], zero pad
  output      logic [0:0]  m_tuser,  // invalid[0]
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [11:0] cfg_data
);

  logic        in_valid;
  logic [7:0]  in_ch;
  logic        in_first;
  logic        in_last;
  logic [11:0] in_mode;
  logic        in_dir;
  logic [11:0] umask_bits;
  smp_state_t  state;
  smp_state_t  state_next;
  logic [11:0] res_mode;
  logic        res_invalid;
  logic [11:0] out_mode;
  logic        out_invalid;
  logic        advance;

  assign advance   = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'd0, out_mode};
  assign m_tuser   = out_invalid;

  smp_step u_step (
    .state_cur    (state),
    .ch           (in_ch),
    .first        (in_first),
    .start_mode   (in_mode),
    .is_directory (in_dir),
    .umask_bits   (umask_bits),
    .state_next   (state_next),
    .final_mode   (res_mode),
    .invalid      (res_invalid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      state      <= STATE_RESET;
      umask_bits <= UMASK_RESET;
    end else begin
      if (cfg_valid) begin
        umask_bits <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance && in_last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch    <= s_tdata[7:0];
      in_mode  <= s_tdata[19:8];
      in_dir   <= s_tdata[20];
      in_first <= s_tuser[0];
      in_last  <= s_tlast;
    end
    if (advance && in_last) begin
      out_mode    <= res_mode;
      out_invalid <= res_invalid;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/smp_checker.sv @@
`default_nettype none
module smp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  // stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an invalid spec always reports a zero mode, pad bits stay clear
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:12] == 4'd0) && (!m_tuser[0] || m_tdata[11:0] == 12'd0))
    else $error("invalid result with nonzero mode");

  // a free output path never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && m_tready |-> s_tready)
    else $error("input stalled while output ready");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind symbolic_mode_parser smp_checker u_smp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
